FILE: hw/rtl/rrsp_pkg.sv
`timescale 1ns / 1ps
package rrsp_pkg;

	localparam int LEN_BITS = 32;

	localparam int TQ_DEPTH = 4;
	localparam int TQ_AW    = $clog2(TQ_DEPTH);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0] K_STATUS = 3'd0;
	localparam logic [2:0] K_ERROR  = 3'd1;
	localparam logic [2:0] K_INT    = 3'd2;
	localparam logic [2:0] K_BULK   = 3'd3;
	localparam logic [2:0] K_NULL   = 3'd4;
	localparam logic [2:0] K_PROTO  = 3'd5;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_KIND     = 3'd1;
	localparam logic [2:0] E_NO_DIGIT = 3'd2;
	localparam logic [2:0] E_OVERFLOW = 3'd3;
	localparam logic [2:0] E_BAD_LEN  = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       is_cr;
		logic       is_lf;
		logic       is_ws;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_plus;
		logic       is_minus;
		logic       is_colon;
		logic       is_dollar;
	} tok_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic              has_byte;
		logic [7:0]        data;
		logic signed [63:0] number;
		logic [2:0]        cause;
		logic              last;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} oq_wr_t;

endpackage

FILE: hw/rtl/rrsp_front.sv
`timescale 1ns / 1ps
module rrsp_front import rrsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       push,
	output logic       full,
	output logic       tok_valid,
	output tok_t       tok,
	input  logic       tok_take
);

	tok_t              cls;
	tok_t              mem_q [TQ_DEPTH];
	logic [TQ_AW-1:0]  wp_q;
	logic [TQ_AW-1:0]  rp_q;
	logic [TQ_AW:0]    cnt_q;
	logic              wr;
	logic              rd;

	always_comb begin
		cls           = '0;
		cls.data      = rx_byte;
		cls.is_cr     = (rx_byte == CH_CR);
		cls.is_lf     = (rx_byte == CH_LF);
		cls.is_ws     = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
		cls.is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		cls.digit     = 4'(rx_byte - CH_ZERO);
		cls.is_plus   = (rx_byte == CH_PLUS);
		cls.is_minus  = (rx_byte == CH_MINUS);
		cls.is_colon  = (rx_byte == CH_COLON);
		cls.is_dollar = (rx_byte == CH_DOLLAR);
	end

	assign full      = (cnt_q == (TQ_AW+1)'(TQ_DEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rp_q];
	assign wr        = push && !full;
	assign rd        = tok_take && tok_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (TQ_AW+1)'(wr) - (TQ_AW+1)'(rd);
		end
	end

endmodule

FILE: hw/rtl/rrsp_back.sv
`timescale 1ns / 1ps
module rrsp_back import rrsp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   tok_valid,
	input  tok_t   tok,
	output logic   tok_take,
	input  logic   room,
	output oq_wr_t wr
);

	localparam logic [2:0] PH_KIND  = 3'd0;
	localparam logic [2:0] PH_TEXT  = 3'd1;
	localparam logic [2:0] PH_LEAD  = 3'd2;
	localparam logic [2:0] PH_BODY  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_TRAIL = 3'd5;
	localparam logic [2:0] PH_DROP  = 3'd6;

	localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

	logic [2:0]          phase_q, phase_n;
	logic [2:0]          kind_q, kind_n;
	logic                held_cr_q, held_cr_n;
	logic [63:0]         mag_q, mag_n;
	logic                neg_q, neg_n;
	logic                seen_q, seen_n;
	logic                ended_q, ended_n;
	logic                ovf_q, ovf_n;
	logic [LEN_BITS-1:0] left_q, left_n;
	logic                trail_q, trail_n;

	logic [67:0] prod;
	logic [63:0] limit;
	logic        dig_ovf;
	logic [63:0] value;

	function automatic res_t mk_res(logic [2:0] kind, logic has, logic [7:0] data,
		logic [63:0] num, logic [2:0] cause);
		res_t r;
		r.kind     = kind;
		r.has_byte = has;
		r.data     = data;
		r.number   = num;
		r.cause    = cause;
		r.last     = !has;
		return r;
	endfunction

	assign tok_take = tok_valid && room;

	always_comb begin
		limit   = neg_q ? LIM_NEG : LIM_POS;
		prod    = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + 68'(tok.digit);
		dig_ovf = prod > {4'b0, limit};
		value   = neg_q ? (64'd0 - mag_q) : mag_q;
	end

	always_comb begin
		phase_n   = phase_q;
		kind_n    = kind_q;
		held_cr_n = held_cr_q;
		mag_n     = mag_q;
		neg_n     = neg_q;
		seen_n    = seen_q;
		ended_n   = ended_q;
		ovf_n     = ovf_q;
		left_n    = left_q;
		trail_n   = trail_q;
		wr        = '0;

		unique case (phase_q)
			PH_TEXT, PH_LEAD, PH_BODY, PH_DROP: begin
				if (held_cr_q && tok.is_lf) begin
					held_cr_n = 1'b0;
					phase_n   = PH_KIND;
					if (phase_q == PH_TEXT) begin
						wr.v0 = 1'b1;
						wr.r0 = mk_res(kind_q, 1'b0, 8'd0, 64'd0, E_NONE);
					end else if (phase_q == PH_LEAD || phase_q == PH_BODY) begin
						wr.v0 = 1'b1;
						if (!seen_q) begin
							wr.r0 = mk_res(K_PROTO, 1'b0, 8'd0, 64'd0, E_NO_DIGIT);
						end else if (ovf_q) begin
							wr.r0 = mk_res(K_PROTO, 1'b0, 8'd0, 64'd0,
								(kind_q == K_BULK && neg_q) ? E_BAD_LEN : E_OVERFLOW);
						end else if (kind_q == K_INT) begin
							wr.r0 = mk_res(K_INT, 1'b0, 8'd0, value, E_NONE);
						end else if (neg_q && mag_q == 64'd1) begin
							wr.r0 = mk_res(K_NULL, 1'b0, 8'd0, value, E_NONE);
						end else if ((neg_q && mag_q != 64'd0) || (|mag_q[63:LEN_BITS])) begin
							wr.r0 = mk_res(K_PROTO, 1'b0, 8'd0, 64'd0, E_BAD_LEN);
						end else begin
							wr.v0   = 1'b0;
							neg_n   = 1'b0;
							left_n  = mag_q[LEN_BITS-1:0];
							trail_n = 1'b0;
							phase_n = (mag_q == 64'd0) ? PH_TRAIL : PH_DATA;
						end
					end
				end else begin
					held_cr_n = tok.is_cr;
					if (phase_q == PH_TEXT) begin
						if (held_cr_q) begin
							wr.v0 = 1'b1;
							wr.r0 = mk_res(kind_q, 1'b1, CH_CR, 64'd0, E_NONE);
							if (!tok.is_cr) begin
								wr.v1 = 1'b1;
								wr.r1 = mk_res(kind_q, 1'b1, tok.data, 64'd0, E_NONE);
							end
						end else if (!tok.is_cr) begin
							wr.v0 = 1'b1;
							wr.r0 = mk_res(kind_q, 1'b1, tok.data, 64'd0, E_NONE);
						end
					end else if (phase_q == PH_LEAD) begin
						if (!tok.is_cr && !tok.is_ws) begin
							phase_n = PH_BODY;
							if (tok.is_minus) begin
								neg_n = 1'b1;
							end else if (tok.is_digit) begin
								seen_n = 1'b1;
								if (dig_ovf) begin
									ovf_n = 1'b1;
								end else begin
									mag_n = prod[63:0];
								end
							end else if (!tok.is_plus) begin
								ended_n = 1'b1;
							end
						end
					end else if (phase_q == PH_BODY) begin
						if (held_cr_q) begin
							ended_n = 1'b1;
						end else if (!tok.is_cr && !ended_q) begin
							if (tok.is_digit) begin
								seen_n = 1'b1;
								if (!ovf_q) begin
									if (dig_ovf) begin
										ovf_n = 1'b1;
									end else begin
										mag_n = prod[63:0];
									end
								end
							end else begin
								ended_n = 1'b1;
							end
						end
					end
				end
			end
			PH_DATA: begin
				wr.v0  = 1'b1;
				wr.r0  = mk_res(K_BULK, 1'b1, tok.data, 64'd0, E_NONE);
				left_n = left_q - 1'b1;
				if (left_q == LEN_BITS'(1)) begin
					phase_n = PH_TRAIL;
					trail_n = 1'b0;
				end
			end
			PH_TRAIL: begin
				if (!trail_q) begin
					trail_n = 1'b1;
				end else begin
					trail_n = 1'b0;
					phase_n = PH_KIND;
					wr.v0   = 1'b1;
					wr.r0   = mk_res(K_BULK, 1'b0, 8'd0, mag_q, E_NONE);
				end
			end
			default: begin
				held_cr_n = 1'b0;
				mag_n     = '0;
				neg_n     = 1'b0;
				seen_n    = 1'b0;
				ended_n   = 1'b0;
				ovf_n     = 1'b0;
				left_n    = '0;
				trail_n   = 1'b0;
				priority if (tok.is_plus) begin
					kind_n  = K_STATUS;
					phase_n = PH_TEXT;
				end else if (tok.is_minus) begin
					kind_n  = K_ERROR;
					phase_n = PH_TEXT;
				end else if (tok.is_colon) begin
					kind_n  = K_INT;
					phase_n = PH_LEAD;
				end else if (tok.is_dollar) begin
					kind_n  = K_BULK;
					phase_n = PH_LEAD;
				end else begin
					kind_n    = K_STATUS;
					phase_n   = PH_DROP;
					held_cr_n = tok.is_cr;
					wr.v0     = 1'b1;
					wr.r0     = mk_res(K_PROTO, 1'b0, 8'd0, 64'd0, E_KIND);
				end
			end
		endcase

		if (!tok_take) begin
			wr.v0 = 1'b0;
			wr.v1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KIND;
			kind_q    <= K_STATUS;
			held_cr_q <= 1'b0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			ended_q   <= 1'b0;
			ovf_q     <= 1'b0;
			left_q    <= '0;
			trail_q   <= 1'b0;
		end else if (tok_take) begin
			phase_q   <= phase_n;
			kind_q    <= kind_n;
			held_cr_q <= held_cr_n;
			mag_q     <= mag_n;
			neg_q     <= neg_n;
			seen_q    <= seen_n;
			ended_q   <= ended_n;
			ovf_q     <= ovf_n;
			left_q    <= left_n;
			trail_q   <= trail_n;
		end
	end

`ifndef SYNTHESIS
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("bulk payload phase with no bytes left");
	a_held_cr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		held_cr_q |-> (phase_q == PH_TEXT || phase_q == PH_LEAD ||
			phase_q == PH_BODY || phase_q == PH_DROP))
		else $error("held CR outside a line phase");
	a_trail_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && phase_q == PH_TRAIL && trail_q |=> phase_q == PH_KIND)
		else $error("bulk trailer did not return to kind phase");
`endif

endmodule

FILE: hw/rtl/rrsp_outq.sv
`timescale 1ns / 1ps
module rrsp_outq import rrsp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  oq_wr_t wr,
	output logic   room,
	output logic   empty,
	output res_t   head,
	input  logic   pop
);

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_AW:0]   cnt_q;
	logic [OQ_AW-1:0] wp1;
	logic             rd;
	logic [OQ_AW:0]   n_wr;

	assign room  = (cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];
	assign rd    = pop && !empty;
	assign wp1   = wp_q + 1'b1;
	assign n_wr  = (OQ_AW+1)'(wr.v0) + (OQ_AW+1)'(wr.v1);

	always_ff @(posedge clk) begin
		if (wr.v0) begin
			mem_q[wp_q] <= wr.r0;
		end
		if (wr.v1) begin
			mem_q[wp1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OQ_AW'(n_wr);
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + n_wr - (OQ_AW+1)'(rd);
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.v0 || wr.v1) |-> cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2))
		else $error("result write without room");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr.v1 |-> wr.v0)
		else $error("second result slot written alone");
`endif

endmodule

FILE: hw/rtl/resp_reply_stream_parser.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Words
// input     in         push / full      rx_byte
// result    out        empty / pop      reply_kind, has_byte, data_byte, number,
//                                       error_cause, last
//
// One byte is taken per cycle unless full; each byte leaves zero, one or two result words.
// The parser loop handles one byte per cycle while the result queue has two free entries.
// Words pass from the byte queue through the parser into the result queue, which drains one word per cycle.
// Reset clears both queues and puts the parser in front of a new reply.
// full rises only when the four-entry byte queue is full; the parser waits while the
// result queue has fewer than two free entries.
module resp_reply_stream_parser import rrsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  logic               push,
	output logic               full,
	output logic [2:0]         reply_kind,
	output logic               has_byte,
	output logic [7:0]         data_byte,
	output logic signed [63:0] number,
	output logic [2:0]         error_cause,
	output logic               last,
	output logic               empty,
	input  logic               pop
);

	tok_t   tok;
	logic   tok_valid;
	logic   tok_take;
	logic   room;
	oq_wr_t wr;
	res_t   head;

	rrsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.push      (push),
		.full      (full),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take)
	);

	rrsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take),
		.room      (room),
		.wr        (wr)
	);

	rrsp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.empty  (empty),
		.head   (head),
		.pop    (pop)
	);

	assign reply_kind  = head.kind;
	assign has_byte    = head.has_byte;
	assign data_byte   = head.data;
	assign number      = head.number;
	assign error_cause = head.cause;
	assign last        = head.last;

endmodule
